/* rtl/core/decimal_text_to_integer_macros.svh */
// Assertion helpers used by the checker file.
`ifndef DECIMAL_TEXT_TO_INTEGER_MACROS_SVH
`define DECIMAL_TEXT_TO_INTEGER_MACROS_SVH

// Same-cycle implication, muted while reset is low.
`define DTOI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtoi check failed");

// Next-cycle implication, muted while reset is low.
`define DTOI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtoi check failed");

`endif

/* rtl/core/dtoi_pkg.sv */
`default_nettype none
package dtoi_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] CH_NUL      = 8'd0;
    localparam logic [7:0] CH_DIGIT_LO = 8'd48;
    localparam logic [7:0] CH_DIGIT_HI = 8'd57;
    localparam logic [7:0] CH_MINUS    = 8'd45;

    localparam int unsigned DIGIT_W = 5;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX         = 5'd19;
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT_RESET = 5'd19;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    // register index sits at paddr[2]
    localparam logic REG_DIGIT_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        CK_OTHER,
        CK_NUL,
        CK_DIGIT,
        CK_MINUS
    } t_char_kind;

    typedef struct packed {
        t_char_kind kind;
        logic [3:0] digit;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0] magnitude;
        logic               minus;
        logic               cut;
        logic [DIGIT_W-1:0] count;
    } t_raw;

endpackage
`default_nettype wire

/* rtl/core/dtoi_front.sv */
`default_nettype none
module dtoi_front import dtoi_pkg::*; (
    input  wire logic       i_valid,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_full,
    output logic            o_ready,
    output logic            o_push,
    output t_item           o_item
);

    // sort the byte into the few kinds the back end cares about
    always_comb begin
        o_item.digit = i_text_byte[3:0];
        o_item.last  = i_last_byte;
        if (i_text_byte == CH_NUL) begin
            o_item.kind = CK_NUL;
        end else if (i_text_byte >= CH_DIGIT_LO && i_text_byte <= CH_DIGIT_HI) begin
            o_item.kind = CK_DIGIT;
        end else if (i_text_byte == CH_MINUS) begin
            o_item.kind = CK_MINUS;
        end else begin
            o_item.kind = CK_OTHER;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule
`default_nettype wire

/* rtl/core/dtoi_queue.sv */
`default_nettype none
module dtoi_queue import dtoi_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output logic       o_full,
    output logic       o_nonempty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign wr_en      = i_push && !o_full;
    assign rd_en      = i_pop && o_nonempty;
    assign o_item     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/dtoi_back.sv */
`default_nettype none
module dtoi_back import dtoi_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_item              i_item,
    input  wire logic               i_item_valid,
    input  wire logic [DIGIT_W-1:0] i_limit,
    input  wire logic               i_raw_ready,
    output logic                    o_pop,
    output logic                    o_raw_push,
    output t_raw                    o_raw
);

    logic [VALUE_W-1:0] r_magnitude, n_magnitude;
    logic [DIGIT_W-1:0] r_digits_taken, n_digits_taken;
    logic               r_seen_digit, n_seen_digit;
    logic               r_minus_seen, n_minus_seen;
    logic               r_stopped, n_stopped;
    logic               r_limit_hit, n_limit_hit;

    // a closing byte waits until the result stage has room
    assign o_pop      = i_item_valid && (!i_item.last || i_raw_ready);
    assign o_raw_push = o_pop && i_item.last;

    always_comb begin
        n_magnitude    = r_magnitude;
        n_digits_taken = r_digits_taken;
        n_seen_digit   = r_seen_digit;
        n_minus_seen   = r_minus_seen;
        n_stopped      = r_stopped;
        n_limit_hit    = r_limit_hit;
        if (!r_stopped) begin
            case (i_item.kind)
                CK_NUL: begin
                    n_stopped = 1'b1;
                end
                CK_DIGIT: begin
                    if (r_digits_taken < i_limit) begin
                        // times ten as 8x + 2x
                        n_magnitude    = (r_magnitude << 3) + (r_magnitude << 1)
                                       + VALUE_W'(i_item.digit);
                        n_digits_taken = r_digits_taken + DIGIT_W'(1);
                        n_seen_digit   = 1'b1;
                    end else begin
                        n_limit_hit = 1'b1;
                        n_stopped   = 1'b1;
                    end
                end
                CK_MINUS: begin
                    if (!r_seen_digit) begin
                        n_minus_seen = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_raw.magnitude = n_magnitude;
        o_raw.minus     = n_minus_seen;
        o_raw.cut       = n_limit_hit;
        o_raw.count     = n_digits_taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magnitude    <= '0;
            r_digits_taken <= '0;
            r_seen_digit   <= 1'b0;
            r_minus_seen   <= 1'b0;
            r_stopped      <= 1'b0;
            r_limit_hit    <= 1'b0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_magnitude    <= '0;
                r_digits_taken <= '0;
                r_seen_digit   <= 1'b0;
                r_minus_seen   <= 1'b0;
                r_stopped      <= 1'b0;
                r_limit_hit    <= 1'b0;
            end else begin
                r_magnitude    <= n_magnitude;
                r_digits_taken <= n_digits_taken;
                r_seen_digit   <= n_seen_digit;
                r_minus_seen   <= n_minus_seen;
                r_stopped      <= n_stopped;
                r_limit_hit    <= n_limit_hit;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/dtoi_format.sv */
`default_nettype none
module dtoi_format import dtoi_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_raw_push,
    input  wire t_raw                 i_raw,
    output logic                      o_raw_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_digits_cut,
    output logic                      o_saturated,
    output logic [DIGIT_W-1:0]        o_digit_count
);

    t_raw                      r_raw;
    logic                      r_raw_valid;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_cut;
    logic                      r_sat;
    logic [DIGIT_W-1:0]        r_count;

    logic                      move;
    logic signed [VALUE_W-1:0] n_value;
    logic                      n_sat;

    assign move        = r_raw_valid && (!r_out_valid || i_out_ready);
    assign o_raw_ready = !r_raw_valid || move;

    // clamp to the signed limits, then apply the sign
    always_comb begin
        if (r_raw.minus) begin
            n_sat   = r_raw.magnitude[VALUE_W-1] && (|r_raw.magnitude[VALUE_W-2:0]);
            n_value = n_sat ? {1'b1, {(VALUE_W-1){1'b0}}}
                            : $signed(VALUE_W'(0) - r_raw.magnitude);
        end else begin
            n_sat   = r_raw.magnitude[VALUE_W-1];
            n_value = n_sat ? {1'b0, {(VALUE_W-1){1'b1}}} : $signed(r_raw.magnitude);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_raw_push) begin
                r_raw_valid <= 1'b1;
            end else if (move) begin
                r_raw_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_raw_push) begin
            r_raw <= i_raw;
        end
        if (move) begin
            r_value <= n_value;
            r_sat   <= n_sat;
            r_cut   <= r_raw.cut;
            r_count <= r_raw.count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_digits_cut  = r_cut;
    assign o_saturated   = r_sat;
    assign o_digit_count = r_count;

endmodule
`default_nettype wire

/* rtl/core/decimal_text_to_integer.sv */
`default_nettype none
// Decimal text to signed 64-bit integer. Feed a string one byte per transfer on
// the input channel and mark its final byte with i_last_byte; that byte yields
// exactly one result transfer (value, digits_cut, saturated, digit_count) and
// clears the parser for the next string. Digits accumulate up to digit_limit
// (register 0, reset 19, values above 19 act as 19); a further digit stops
// parsing and sets digits_cut, a zero byte stops parsing silently, and a '-'
// before the first digit makes the result negative. Values beyond the signed
// 64-bit range clamp to the nearest limit and set saturated. Throughput is one
// byte per clock while the queue has room and no closing byte waits on the
// result stage: the accumulator does one times-ten-plus-digit update per cycle.
// The queue is written when a byte is taken, the result stage registers the
// accumulator's raw result when the closing byte is popped, and the clamp and
// sign stage then loads the output register. A two-entry queue parts the byte
// classifier from the accumulator, and the result path has its own stage plus
// output register, so input keeps flowing while a result waits.
module decimal_text_to_integer import dtoi_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // byte input channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [7:0]              i_text_byte,
    input  wire logic                    i_last_byte,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [VALUE_W-1:0]    o_value,
    output logic                         o_digits_cut,
    output logic                         o_saturated,
    output logic [DIGIT_W-1:0]           o_digit_count,
    // configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [CFG_ADDR_W-1:0]   paddr,
    input  wire logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready
);

    // Configuration: keep the raw register for readback and a clamped copy
    // that the accumulator compares against.
    logic [DIGIT_W-1:0] r_digit_limit;
    logic [DIGIT_W-1:0] r_limit_eff;
    logic               cfg_wr;
    logic [DIGIT_W-1:0] wdata;

    assign pready = 1'b1;
    assign wdata  = pwdata[DIGIT_W-1:0];
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[CFG_ADDR_W-1] == REG_DIGIT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_limit <= DIGIT_LIMIT_RESET;
            r_limit_eff   <= DIGIT_LIMIT_RESET;
        end else if (cfg_wr) begin
            r_digit_limit <= wdata;
            r_limit_eff   <= (wdata > DIGIT_MAX) ? DIGIT_MAX : wdata;
        end
    end

    // Read back register 0; everything else reads as zero.
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_DIGIT_LIMIT)
                    ? {{(CFG_DATA_W-DIGIT_W){1'b0}}, r_digit_limit}
                    : '0;

    // Front: classify the incoming byte and push it into the queue.
    t_item front_item;
    t_item queue_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_nonempty;

    dtoi_front u_front (
        .i_valid     (i_in_valid),
        .i_text_byte (i_text_byte),
        .i_last_byte (i_last_byte),
        .i_full      (q_full),
        .o_ready     (o_in_ready),
        .o_push      (push),
        .o_item      (front_item)
    );

    dtoi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (front_item),
        .i_pop      (pop),
        .o_item     (queue_item),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    // Back: accumulate digits; a closing byte hands the raw result onward.
    t_raw raw;
    logic raw_push;
    logic raw_ready;

    dtoi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (queue_item),
        .i_item_valid (q_nonempty),
        .i_limit      (r_limit_eff),
        .i_raw_ready  (raw_ready),
        .o_pop        (pop),
        .o_raw_push   (raw_push),
        .o_raw        (raw)
    );

    // Result path: clamp, apply the sign, hold until the transfer completes.
    dtoi_format u_format (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_raw_push    (raw_push),
        .i_raw         (raw),
        .o_raw_ready   (raw_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_digits_cut  (o_digits_cut),
        .o_saturated   (o_saturated),
        .o_digit_count (o_digit_count)
    );

endmodule
`default_nettype wire

/* rtl/core/dtoi_checker.sv */
`default_nettype none
`include "decimal_text_to_integer_macros.svh"
module dtoi_checker import dtoi_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire logic signed [VALUE_W-1:0] o_value,
    input wire logic                      o_saturated,
    input wire logic [DIGIT_W-1:0]        o_digit_count
);

    // a stalled result holds
    `DTOI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_value) && $stable(o_digit_count))

    // clamping only ever lands on one of the two limits
    `DTOI_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, o_out_valid && o_saturated, o_value == {1'b0, {(VALUE_W-1){1'b1}}} || o_value == {1'b1, {(VALUE_W-1){1'b0}}})

    // fewer than nineteen digits cannot leave the signed range
    `DTOI_ASSERT_IMP(a_sat_digits, i_clk, i_rst_n, o_out_valid && o_saturated, o_digit_count == DIGIT_MAX)

    // no digits means a zero value
    `DTOI_ASSERT_IMP(a_no_digits, i_clk, i_rst_n, o_out_valid && o_digit_count == '0, o_value == '0 && !o_saturated)

endmodule

bind decimal_text_to_integer dtoi_checker u_dtoi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_value       (o_value),
    .o_saturated   (o_saturated),
    .o_digit_count (o_digit_count)
);
`default_nettype wire
